FILE: src/tkcpd_pkg.sv
// shared types and constants for the top-k correlation peak picker
package tkcpd_pkg;

  localparam int HELD    = 4;
  localparam int VAL_W   = 32;
  localparam int LAG_W   = 16;
  localparam int CNT_W   = 17;
  localparam int EXP_W   = 5;
  localparam int RANK_W  = 5;
  localparam int LEFT_W  = $clog2(HELD + 1);
  localparam int OUT_W   = 56;

  localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(10);
  localparam logic [EXP_W-1:0] EXP_MIN   = EXP_W'(1);
  localparam logic [EXP_W-1:0] EXP_MAX   = EXP_W'(16);

  // one table slot
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [LAG_W-1:0]        lag;
  } slot_t;

  // one result waiting in the emit chain
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [LAG_W-1:0]        delay;
  } snap_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic                    ins_en;
    logic                    load;
    logic                    shift;
    logic signed [VAL_W-1:0] cand_value;
    logic [LAG_W-1:0]        cand_lag;
    logic [CNT_W-1:0]        half_len;
    logic [LAG_W-1:0]        len_lo;
  } cell_ctrl_t;

endpackage

FILE: src/tkcpd_cell.sv
// one slot of the descending peak table plus its emit stage
module tkcpd_cell
  import tkcpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       ge_prev,
  input  slot_t      slot_prev,
  input  snap_t      snap_in,
  output logic       ge,
  output slot_t      slot,
  output snap_t      snap
);

  slot_t slot_next;
  snap_t conv;

  assign ge = !slot.valid || (ctrl.cand_value >= slot.value);

  always_comb begin
    slot_next = slot;
    if (ctrl.ins_en && ge_prev) begin
      slot_next = slot_prev;
    end else if (ctrl.ins_en && ge) begin
      slot_next.valid = 1'b1;
      slot_next.value = ctrl.cand_value;
      slot_next.lag   = ctrl.cand_lag;
    end
  end

  // circular wrap of the lag into a signed delay
  always_comb begin
    conv = '0;
    if (slot_next.valid) begin
      conv.valid = 1'b1;
      conv.value = slot_next.value;
      if ({1'b0, slot_next.lag} < ctrl.half_len) begin
        conv.delay = slot_next.lag;
      end else begin
        conv.delay = slot_next.lag - ctrl.len_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (ctrl.load) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap <= '0;
    end else if (ctrl.load) begin
      snap <= conv;
    end else if (ctrl.shift) begin
      snap <= snap_in;
    end
  end

endmodule

FILE: src/top_k_correlation_peak_delays.sv
// top level: lag counter, chain of peak cells and result streaming
// a frame's results start in the cycle after the word marked tlast is taken
// throughput: one correlation word per cycle; each frame emits HELD words, one per cycle while m_tready is high
// a word marked tlast waits while results of the previous frame are still draining
// other words are taken every cycle, even during draining
// reset (rst, synchronous, active high) clears the table, lag counter and pending results,
// and sets fft_len_log2 to 10
module top_k_correlation_peak_delays
  import tkcpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration: fft_len_log2
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [EXP_W-1:0]  cfg_data,
  // correlation stream in
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [VAL_W-1:0]  s_tdata,   // [31:0] cc_value
  input  logic              s_tlast,   // frame_end
  // results out
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [4:0] rank, [20:5] sample_delay,
                                        // [52:21] peak_value, [55:53] zero
  output logic              m_tuser,   // [0] entry_valid
  output logic              m_tlast    // last_result
);

  logic [EXP_W-1:0]  fft_len_log2;
  logic [EXP_W-1:0]  exp_eff;
  logic [CNT_W-1:0]  frame_len;
  logic [CNT_W-1:0]  lag_counter;
  logic [LEFT_W-1:0] left;
  logic              s_fire;
  logic              m_fire;
  logic              free;
  logic              in_range;
  logic              reject;
  cell_ctrl_t        ctrl;

  logic              ge_chain   [HELD+1];
  slot_t             slot_chain [HELD+1];
  snap_t             snap_chain [HELD+1];
  logic [HELD-1:0]   vmask;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_len_log2 <= EXP_RESET;
    end else if (cfg_valid) begin
      fft_len_log2 <= cfg_data;
    end
  end

  // clamp the exponent into 1..16 and form the frame length
  always_comb begin
    exp_eff = fft_len_log2;
    if (fft_len_log2 < EXP_MIN) exp_eff = EXP_MIN;
    if (fft_len_log2 > EXP_MAX) exp_eff = EXP_MAX;
  end
  assign frame_len = CNT_W'(1) << exp_eff;

  // emit chain can take a new snapshot when empty or when its last word leaves now
  assign m_fire   = m_tvalid && m_tready;
  assign free     = (left == '0) || ((left == LEFT_W'(1)) && m_tready);
  assign s_tready = free || !s_tlast;
  assign s_fire   = s_tvalid && s_tready;

  // drop values past the frame length and values that cannot beat the smallest held one
  assign in_range = lag_counter < frame_len;
  assign reject   = slot_chain[HELD].valid && (signed'(s_tdata) <= slot_chain[HELD].value);

  always_comb begin
    ctrl            = '0;
    ctrl.ins_en     = s_fire && in_range && !reject;
    ctrl.load       = s_fire && s_tlast;
    ctrl.shift      = m_fire;
    ctrl.cand_value = signed'(s_tdata);
    ctrl.cand_lag   = lag_counter[LAG_W-1:0];
    ctrl.half_len   = frame_len >> 1;
    ctrl.len_lo     = frame_len[LAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_counter <= '0;
    end else if (s_fire && s_tlast) begin
      lag_counter <= '0;
    end else if (s_fire && in_range) begin
      lag_counter <= lag_counter + CNT_W'(1);
    end
  end

  // words left to send from the emit chain
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (ctrl.load) begin
      left <= LEFT_W'(HELD);
    end else if (m_fire) begin
      left <= left - LEFT_W'(1);
    end
  end

  // the chain: cell i looks at cell i-1 for shift-in on insert,
  // and at cell i+1 for shift-up while emitting
  assign ge_chain[0]      = 1'b0;
  assign slot_chain[0]    = '0;
  assign snap_chain[HELD] = '0;

  for (genvar i = 0; i < HELD; i++) begin : g_cell
    slot_t cell_slot;
    snap_t cell_snap;

    tkcpd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .ge_prev   (ge_chain[i]),
      .slot_prev (slot_chain[i]),
      .snap_in   (snap_chain[i+1]),
      .ge        (ge_chain[i+1]),
      .slot      (cell_slot),
      .snap      (cell_snap)
    );

    assign slot_chain[i+1] = cell_slot;
    assign snap_chain[i]   = cell_snap;
    assign vmask[i]        = cell_slot.valid;
  end

  // cell 0 of the emit chain drives the output
  assign m_tvalid = (left != '0);
  assign m_tlast  = (left == LEFT_W'(1));
  assign m_tuser  = snap_chain[0].valid;
  assign m_tdata  = {3'b000,
                     snap_chain[0].value,
                     snap_chain[0].delay,
                     RANK_W'(LEFT_W'(HELD) - left)};

  // a frame end always queues a full set of results
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tlast) |=> (left == LEFT_W'(HELD)))
    else $error("emit count not loaded on frame end");

  // the lag counter restarts and the table empties after a frame end
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tlast) |=> (lag_counter == '0) && (vmask == '0))
    else $error("table or lag counter not cleared on frame end");

  // filled slots always form a prefix of the table
  assert property (@(posedge clk) disable iff (rst)
    ((vmask >> 1) & ~vmask) == '0)
    else $error("hole in peak table");

  // the input only stalls for a frame end while results are draining
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s_tlast && (left != '0)))
    else $error("input stalled without cause");

endmodule
